// ===== rtl/core/rdsm_pkg.sv =====
// ----------------------------------------------------------------------------
// rdsm_pkg
// Shared types, constants and the star-skip closure for the dot-star matcher.
// ----------------------------------------------------------------------------
package rdsm_pkg;

  localparam int MAX_TOKENS = 16;
  localparam int LIVE_W     = MAX_TOKENS + 1;
  localparam int TOK_W      = $clog2(MAX_TOKENS + 1);
  localparam int CHAR_W     = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHARS_LOW  = 3'd0,
    REG_CHARS_HIGH = 3'd1,
    REG_ANY_MASK   = 3'd2,
    REG_STAR_MASK  = 3'd3,
    REG_TOKENS     = 3'd4
  } rdsm_reg_t;

  // Pattern as seen by the front and back
  typedef struct packed {
    logic [2*CFG_DATA_W-1:0] chars;      // token k in bits 8k+7..8k
    logic [MAX_TOKENS-1:0]   any_mask;
    logic [MAX_TOKENS-1:0]   star_eff;   // star bits of tokens in use
    logic [MAX_TOKENS-1:0]   tok_mask;   // tokens in use
    logic [LIVE_W-1:0]       pos_mask;   // positions 0..count
    logic [LIVE_W-1:0]       end_sel;    // one-hot end position
    logic [LIVE_W-1:0]       start_live; // closure of position 0
  } rdsm_cfg_t;

  // Classified item in the queue
  typedef struct packed {
    logic [MAX_TOKENS-1:0] hit;   // token k accepts this byte
    logic                  last;
    logic                  empty;
  } rdsm_item_t;

  // Star-skip closure as a parallel prefix: c[k] = v[k] | star[k-1] & c[k-1]
  function automatic logic [LIVE_W-1:0] star_closure(
    input logic [LIVE_W-1:0]     v,
    input logic [MAX_TOKENS-1:0] s
  );
    logic [LIVE_W-1:0] g;
    logic [LIVE_W-1:0] p;
    logic [LIVE_W-1:0] g_n;
    logic [LIVE_W-1:0] p_n;
    g = v;
    p = {s, 1'b0};
    for (int d = 1; d < LIVE_W; d = d * 2) begin
      g_n = g;
      p_n = p;
      for (int k = d; k < LIVE_W; k++) begin
        g_n[k] = g[k] | (p[k] & g[k-d]);
        p_n[k] = p[k] & p[k-d];
      end
      g = g_n;
      p = p_n;
    end
    return g;
  endfunction

endpackage

// ===== rtl/core/rdsm_cfg.sv =====
// ----------------------------------------------------------------------------
// rdsm_cfg
// Pattern registers and the masks and start vector derived from them.
// ----------------------------------------------------------------------------
module rdsm_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rdsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rdsm_pkg::CFG_DATA_W-1:0]    cfg_data,
  output rdsm_pkg::rdsm_cfg_t                cfg
);
  import rdsm_pkg::*;

  logic [CFG_DATA_W-1:0] chars_low;
  logic [CFG_DATA_W-1:0] chars_high;
  logic [MAX_TOKENS-1:0] any_mask;
  logic [MAX_TOKENS-1:0] star_mask;
  logic [TOK_W-1:0]      tokens;
  logic [LIVE_W-1:0]     start_live;

  logic [TOK_W-1:0]      tcount;
  logic [MAX_TOKENS-1:0] tok_mask;
  logic [LIVE_W-1:0]     pos_mask;
  logic [LIVE_W-1:0]     end_sel;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      chars_low  <= '0;
      chars_high <= '0;
      any_mask   <= '0;
      star_mask  <= '0;
      tokens     <= '0;
      start_live <= '0;
    end else begin
      if (cfg_we) begin
        case (rdsm_reg_t'(cfg_index))
          REG_CHARS_LOW:  chars_low  <= cfg_data;
          REG_CHARS_HIGH: chars_high <= cfg_data;
          REG_ANY_MASK:   any_mask   <= cfg_data[MAX_TOKENS-1:0];
          REG_STAR_MASK:  star_mask  <= cfg_data[MAX_TOKENS-1:0];
          REG_TOKENS:     tokens     <= cfg_data[TOK_W-1:0];
          default: ;
        endcase
      end
      // start vector is registered from the pattern registers and follows them in the next cycle
      start_live <= star_closure(LIVE_W'(1), star_mask & tok_mask) & pos_mask;
    end
  end

  // saturated token count and the masks it sets
  always_comb begin
    tcount = (tokens > TOK_W'(MAX_TOKENS)) ? TOK_W'(MAX_TOKENS) : tokens;
    for (int k = 0; k < MAX_TOKENS; k++) begin
      tok_mask[k] = (TOK_W'(k) < tcount);
    end
    for (int k = 0; k < LIVE_W; k++) begin
      pos_mask[k] = (TOK_W'(k) <= tcount);
      end_sel[k]  = (TOK_W'(k) == tcount);
    end
  end

  assign cfg.chars      = {chars_high, chars_low};
  assign cfg.any_mask   = any_mask;
  assign cfg.star_eff   = star_mask & tok_mask;
  assign cfg.tok_mask   = tok_mask;
  assign cfg.pos_mask   = pos_mask;
  assign cfg.end_sel    = end_sel;
  assign cfg.start_live = start_live;

endmodule

// ===== rtl/core/rdsm_front.sv =====
// ----------------------------------------------------------------------------
// rdsm_front
// Takes subject beats and compares the byte against every token at once.
// ----------------------------------------------------------------------------
module rdsm_front (
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [rdsm_pkg::CHAR_W-1:0]   char_in,
  input  logic                          last_char,
  input  logic                          empty_string,
  input  rdsm_pkg::rdsm_cfg_t           cfg,
  output logic                          push_valid,
  input  logic                          push_ready,
  output rdsm_pkg::rdsm_item_t          push_item
);
  import rdsm_pkg::*;

  logic [MAX_TOKENS-1:0] hit;

  // per-token byte compare
  always_comb begin
    for (int k = 0; k < MAX_TOKENS; k++) begin
      hit[k] = cfg.tok_mask[k] &
               (cfg.any_mask[k] | (cfg.chars[k*CHAR_W +: CHAR_W] == char_in));
    end
  end

  assign s_tready        = push_ready;
  assign push_valid      = s_tvalid;
  assign push_item.hit   = hit;
  assign push_item.last  = last_char;
  assign push_item.empty = empty_string;

endmodule

// ===== rtl/core/rdsm_fifo.sv =====
// ----------------------------------------------------------------------------
// rdsm_fifo
// Short queue of classified beats between front and back.
// ----------------------------------------------------------------------------
module rdsm_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  rdsm_pkg::rdsm_item_t  push_item,
  output logic                  pop_valid,
  input  logic                  pop,
  output rdsm_pkg::rdsm_item_t  pop_item
);
  import rdsm_pkg::*;

  rdsm_item_t          mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop & pop_valid;
  assign pop_item   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/rdsm_back.sv =====
// ----------------------------------------------------------------------------
// rdsm_back
// Advances the live-position vector one beat per cycle unless a pending result stalls it; reports the match.
// ----------------------------------------------------------------------------
module rdsm_back (
  input  logic                          clk,
  input  logic                          rst,
  input  rdsm_pkg::rdsm_cfg_t           cfg,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  rdsm_pkg::rdsm_item_t          q_item,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic                          matched
);
  import rdsm_pkg::*;

  logic [LIVE_W-1:0]     live;
  logic                  in_subj;
  logic                  out_valid;
  logic                  out_matched;

  logic                  term;
  logic                  out_free;
  logic [LIVE_W-1:0]     base;
  logic [MAX_TOKENS-1:0] step;
  logic [LIVE_W-1:0]     adv;
  logic [LIVE_W-1:0]     live_next;
  logic                  res;

  // pop when the beat makes no result or the output slot frees up
  assign term     = q_item.last | q_item.empty;
  assign out_free = ~out_valid | m_tready;
  assign q_pop    = q_valid & (~term | out_free);

  // one step of the position vector
  always_comb begin
    base      = in_subj ? (live & cfg.pos_mask) : cfg.start_live;
    step      = base[MAX_TOKENS-1:0] & q_item.hit;
    adv       = {1'b0, step & cfg.star_eff} | {step & ~cfg.star_eff, 1'b0};
    live_next = star_closure(adv, cfg.star_eff) & cfg.pos_mask;
    if (q_item.empty) begin
      res = |(cfg.start_live & cfg.end_sel);
    end else begin
      res = |(live_next & cfg.end_sel);
    end
  end

  // subject state
  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= '0;
      in_subj <= 1'b0;
    end else if (q_pop) begin
      if (term) begin
        live    <= '0;
        in_subj <= 1'b0;
      end else begin
        live    <= live_next;
        in_subj <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && term) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && term) begin
      out_matched <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign matched  = out_matched;

  // a finished subject always lands in the output register
  a_term_to_out: assert property (@(posedge clk) disable iff (rst)
    q_pop && term |=> m_tvalid)
    else $error("terminal beat did not produce a result");

  // a finished subject leaves no live positions behind
  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    q_pop && term |=> !in_subj && live == '0)
    else $error("subject state not cleared after result");

  // no result may be overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !(q_pop && term))
    else $error("pending result overwritten");

endmodule

// ===== rtl/core/regex_dot_star_matcher_unit.sv =====
// Path: a taken beat is written into the queue, and its result is registered in the back end when it is popped.
// Throughput: one subject byte per cycle while no pending result stalls the back end, which
//   updates the live-position vector combinationally; a four-entry queue decouples the sides.
// Reset: synchronous on rst; clears pattern registers to zero, empties the queue,
//   drops any subject in progress and any pending result.
// ----------------------------------------------------------------------------
// regex_dot_star_matcher_unit
// Whole-string matcher for patterns of literal and dot tokens with stars.
// ----------------------------------------------------------------------------
module regex_dot_star_matcher_unit (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [rdsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rdsm_pkg::CFG_DATA_W-1:0]    cfg_data,
  // subject stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [7:0] char_in
  input  logic                               s_tlast,   // last_char
  input  logic                               s_tuser,   // empty_string
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [7:0]                         m_tdata    // [0] matched, [7:1] zero
);
  import rdsm_pkg::*;

  rdsm_cfg_t  cfg;
  logic       push_valid;
  logic       push_ready;
  rdsm_item_t push_item;
  logic       q_valid;
  logic       q_pop;
  rdsm_item_t q_item;
  logic       matched;

  rdsm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rdsm_front u_front (
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .char_in      (s_tdata),
    .last_char    (s_tlast),
    .empty_string (s_tuser),
    .cfg          (cfg),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  rdsm_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  rdsm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .matched  (matched)
  );

  assign m_tdata = {7'b0, matched};

endmodule

// ===== test/tb_regex_dot_star_matcher_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_regex_dot_star_matcher_unit
// Drives subject bytes into the dot-star matcher under a series of compiled
// patterns. A shadow copy of the pattern registers and the live-position
// vector predicts every match bit, which is checked against each result beat
// in order. Both sides idle at random, and the receiver holds off once for a
// long stretch so that the input side backs up.
// ----------------------------------------------------------------------------
module tb_regex_dot_star_matcher_unit;
  import rdsm_pkg::*;

  localparam int          DRAIN_CYCLES = 20;
  localparam int          HOLD_CYCLES  = 100;
  localparam int          QUIET_LIMIT  = 1000;
  localparam int          ITEM_TARGET  = 1600;
  localparam logic [7:0]  STAR_CH      = 8'h2A;
  localparam logic [7:0]  DOT_CH       = 8'h2E;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       empty;
  } subj_beat_t;

  typedef logic [7:0] byte_q_t[$];

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = '0;   // [7:0] char_in
  logic                  s_tlast   = 1'b0; // last_char
  logic                  s_tuser   = 1'b0; // empty_string
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [7:0]            m_tdata;          // [0] matched, [7:1] zero

  // shadow pattern registers
  logic [127:0]          pat_chars = '0;
  logic [15:0]           pat_dot   = '0;
  logic [15:0]           pat_star  = '0;
  logic [4:0]            pat_count = '0;

  // predicted matcher state
  logic [LIVE_W-1:0]     live_pos   = '0;
  logic                  in_subject = 1'b0;

  subj_beat_t            pending_beats[$];
  logic                  match_q[$];

  logic                  in_beat  = 1'b0;
  logic                  out_beat = 1'b0;
  bit                    tx_idle_on = 1'b1;
  bit                    rx_idle_on = 1'b1;
  int unsigned           tx_wait = 0;
  int unsigned           rx_wait = 0;
  int unsigned           hold_req = 0;
  int unsigned           hold_ack = 0;
  int unsigned           hold_left = 0;
  int unsigned           fail_count = 0;
  int unsigned           items_sent = 0;
  int unsigned           quiet_cycles = 0;

  regex_dot_star_matcher_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------- match predictor ----------------

  function automatic int unsigned used_tokens();
    return (pat_count > MAX_TOKENS) ? MAX_TOKENS : int'(pat_count);
  endfunction

  function automatic logic [LIVE_W-1:0] position_mask(int unsigned n);
    logic [LIVE_W-1:0] m;
    m = '0;
    for (int k = 0; k <= n; k++) m[k] = 1'b1;
    return m;
  endfunction

  // a live starred token may be skipped
  function automatic logic [LIVE_W-1:0] skip_starred(logic [LIVE_W-1:0] v, int unsigned n);
    logic [LIVE_W-1:0] r;
    r = v;
    for (int k = 0; k < n; k++)
      if (r[k] && pat_star[k]) r[k+1] = 1'b1;
    return r & position_mask(n);
  endfunction

  function automatic void advance_matcher(logic [7:0] c, logic last, logic empty);
    int unsigned       n;
    logic [LIVE_W-1:0] cur;
    logic [LIVE_W-1:0] nxt;
    n = used_tokens();
    // empty subject: judge from the start position alone
    if (empty) begin
      cur = skip_starred(LIVE_W'(1), n);
      match_q.push_back(cur[n]);
      live_pos   = '0;
      in_subject = 1'b0;
      return;
    end
    cur = in_subject ? (live_pos & position_mask(n)) : skip_starred(LIVE_W'(1), n);
    nxt = '0;
    for (int k = 0; k < n; k++)
      if (cur[k] && (pat_dot[k] || pat_chars[8*k +: 8] == c)) begin
        if (pat_star[k]) nxt[k] = 1'b1;
        else nxt[k+1] = 1'b1;
      end
    nxt = skip_starred(nxt, n);
    if (last) begin
      match_q.push_back(nxt[n]);
      live_pos   = '0;
      in_subject = 1'b0;
    end else begin
      live_pos   = nxt;
      in_subject = 1'b1;
    end
  endfunction

  function automatic void report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t ns", what, got, want, $realtime);
    fail_count++;
  endfunction

  // ---------------- beat sampling, checking, watchdog ----------------
  always @(posedge clk) begin
    logic want;
    in_beat  = (s_tvalid === 1'b1) && (s_tready === 1'b1);
    out_beat = (m_tvalid === 1'b1) && (m_tready === 1'b1);
    if (!rst) begin
      if (in_beat) advance_matcher(s_tdata, s_tlast, s_tuser);
      if (out_beat) begin
        if (match_q.size() == 0) begin
          report_mismatch("unexpected result", m_tdata, 8'h00);
        end else begin
          want = match_q.pop_front();
          if (m_tdata[0] !== want) report_mismatch("matched", m_tdata, {7'b0, want});
          if (m_tdata[7:1] !== 7'b0) report_mismatch("padding", m_tdata, {7'b0, want});
        end
      end
      if (in_beat || out_beat) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no beat for %0d cycles", quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------- subject driver ----------------
  always @(negedge clk) begin
    subj_beat_t nxt;
    if (!rst && !(s_tvalid && !in_beat)) begin
      if (tx_wait > 0) begin
        tx_wait--;
        s_tvalid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        nxt = pending_beats.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= nxt.ch;
        s_tlast  <= nxt.last;
        s_tuser  <= nxt.empty;
        tx_wait = tx_idle_on ? $urandom_range(0, 5) : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- result receiver ----------------
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_ack != hold_req) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (out_beat) rx_wait = rx_idle_on ? $urandom_range(0, 5) : 0;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------- stimulus helpers ----------------

  task automatic write_reg(rdsm_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_CHARS_LOW:  pat_chars[63:0]   = val;
      REG_CHARS_HIGH: pat_chars[127:64] = val;
      REG_ANY_MASK:   pat_dot           = val[15:0];
      REG_STAR_MASK:  pat_star          = val[15:0];
      REG_TOKENS:     pat_count         = val[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_pattern(logic [127:0] ch, logic [15:0] dm, logic [15:0] sm,
                                 logic [4:0] n);
    write_reg(REG_CHARS_LOW, ch[63:0]);
    write_reg(REG_CHARS_HIGH, ch[127:64]);
    write_reg(REG_ANY_MASK, {48'b0, dm});
    write_reg(REG_STAR_MASK, {48'b0, sm});
    write_reg(REG_TOKENS, {59'b0, n});
  endtask

  // compile a pattern text such as "a.b*" into token registers
  task automatic program_text(string p);
    logic [127:0] ch;
    logic [15:0]  dm;
    logic [15:0]  sm;
    int           n;
    ch = '0;
    dm = '0;
    sm = '0;
    n  = 0;
    for (int i = 0; i < p.len(); i++) begin
      if (p[i] == STAR_CH) begin
        if (n > 0) sm[n-1] = 1'b1;
      end else begin
        if (p[i] == DOT_CH) dm[n] = 1'b1;
        else ch[8*n +: 8] = p[i];
        n++;
      end
    end
    program_pattern(ch, dm, sm, n[4:0]);
  endtask

  task automatic push_beat(logic [7:0] c, logic last, logic empty);
    subj_beat_t b;
    b.ch    = c;
    b.last  = last;
    b.empty = empty;
    pending_beats.push_back(b);
    items_sent++;
  endtask

  // small alphabet most of the time so that literals actually hit
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'h61 + 8'($urandom_range(0, 3));
  endfunction

  task automatic push_bytes(byte_q_t q, bit finish);
    if (q.size() == 0) begin
      if (finish) push_beat(pick_byte(), 1'($urandom_range(0, 1)), 1'b1);
    end else begin
      foreach (q[i]) push_beat(q[i], finish && (i == q.size() - 1), 1'b0);
    end
  endtask

  task automatic push_text(string s, bit finish);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    push_bytes(q, finish);
  endtask

  // subject that follows the loaded pattern, sometimes damaged in one place
  function automatic byte_q_t pattern_subject();
    byte_q_t     q;
    int unsigned n;
    int unsigned reps;
    int unsigned at;
    n = used_tokens();
    for (int k = 0; k < n; k++) begin
      reps = pat_star[k] ? $urandom_range(0, 3) : 1;
      for (int r = 0; r < reps; r++)
        q.push_back(pat_dot[k] ? pick_byte() : pat_chars[8*k +: 8]);
    end
    if ($urandom_range(0, 2) == 0 && q.size() > 0) begin
      at = $urandom_range(0, q.size() - 1);
      case ($urandom_range(0, 2))
        0: q[at] = pick_byte();
        1: q.delete(at);
        default: q.insert(at, pick_byte());
      endcase
    end
    return q;
  endfunction

  function automatic byte_q_t noise_subject();
    byte_q_t q;
    int unsigned len;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++)
      q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : pick_byte());
    return q;
  endfunction

  task automatic random_pattern();
    logic [127:0] ch;
    logic [15:0]  dm;
    logic [15:0]  sm;
    logic [4:0]   n;
    for (int k = 0; k < 16; k++) ch[8*k +: 8] = pick_byte();
    dm = 16'($urandom & $urandom);
    sm = 16'($urandom & $urandom);
    case ($urandom_range(0, 9))
      0: n = 5'($urandom_range(17, 31));
      1: n = 5'd16;
      2: n = 5'd0;
      default: n = 5'($urandom_range(1, 10));
    endcase
    case ($urandom_range(0, 11))
      0: ch = '1;
      1: ch = {$urandom, $urandom, $urandom, $urandom};
      2: dm = '1;
      3: sm = '1;
      4: begin dm = '0; sm = '0; end
      default: ;
    endcase
    program_pattern(ch, dm, sm, n);
  endtask

  // block idle: nothing queued, nothing offered, no result owed
  task automatic settle();
    while (!(pending_beats.size() == 0 && !s_tvalid && match_q.size() == 0))
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------- test sequence ----------------
  initial begin
    int unsigned phase;
    int unsigned phase_items;
    byte_q_t     q;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero-token pattern right after reset: only the empty subject matches
    push_beat(8'h5A, 1'b0, 1'b1);
    push_beat(8'h00, 1'b1, 1'b0);
    settle();

    program_text("a.b*");
    push_text("ab", 1);
    push_text("axbbb", 1);
    push_text("a", 1);
    // last and empty together: judged as empty subject
    push_beat(8'hFF, 1'b1, 1'b1);
    // subject abandoned by an empty item, then a fresh one
    push_text("ax", 0);
    push_beat(8'h61, 1'b0, 1'b1);
    push_text("ab", 1);
    settle();

    // all tokens starred, count above the maximum saturates, byte extremes
    program_pattern({64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 16'h0000, 16'hFFFF, 5'd31);
    push_beat(8'hFF, 1'b0, 1'b0);
    push_beat(8'h00, 1'b1, 1'b0);
    push_beat(8'h00, 1'b0, 1'b0);
    push_beat(8'hFF, 1'b1, 1'b0);
    settle();

    // pattern swapped in the middle of a subject keeps the live positions
    program_text("ab");
    push_text("a", 0);
    settle();
    program_text("xb");
    push_text("b", 1);
    settle();

    // random phases
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      random_pattern();
      tx_idle_on = ($urandom_range(0, 2) != 0);
      rx_idle_on = ($urandom_range(0, 2) != 0);
      if (phase == 10) begin
        // receiver stalls long while the sender keeps pushing one-byte subjects
        tx_idle_on = 1'b0;
        hold_req++;
        for (int i = 0; i < 40; i++) push_beat(pick_byte(), 1'b1, 1'b0);
      end
      phase_items = 0;
      while (phase_items < 50) begin
        case ($urandom_range(0, 19))
          0: q = {};
          1: begin
            q = noise_subject();
            push_bytes(q, 0);
            phase_items += q.size();
            q = {};
          end
          2, 3: q = noise_subject();
          default: q = pattern_subject();
        endcase
        push_bytes(q, 1);
        phase_items += (q.size() == 0) ? 1 : q.size();
      end
      // sometimes leave a subject open across the next pattern load
      if ($urandom_range(0, 4) == 0) begin
        q = noise_subject();
        push_bytes(q, 0);
      end
      settle();
      phase++;
    end

    // close any open subject, then wait out the pipeline
    push_beat(pick_byte(), 1'b1, 1'b0);
    settle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
